>>> rtl/sha256_pkg.sv
package sha256_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned NumRounds = 64;

    typedef logic [WordWidth-1:0] word_t;

    typedef struct packed {
        logic load_init;
        logic write_byte;
        logic [5:0] byte_addr;
        logic [7:0] byte_value;
        logic start_block;
        logic shift_digest;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_status_t;

    localparam word_t InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (WordWidth - n));
    endfunction

endpackage

>>> rtl/sha256_stream_hasher_unit.sv
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte, tuser op
// m_axis    out        tdata[31:0] digest_word, tdata[34:32] word_index, tlast last_word
// Absorb bytes are accepted back to back while idle; the 64th byte of a block starts a compression.
// A finish writes the padding bytes and runs one or two compressions,
// then emits eight words, one per cycle while m_axis_tready is high.
// The 64-round loop in the datapath sets the block time.
// Reset is asynchronous and active low; it restores the initial hash value.
// Input is stalled throughout compression and digest output.
module sha256_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word, word_index, zero fill
    output logic        m_axis_tlast    // last_word
);

    dp_cmd_t    cmd;
    dp_status_t status;
    word_t      head_word;
    logic [2:0] index;

    sha256_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (index),
        .cmd       (cmd),
        .status    (status)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .head_word (head_word)
    );

    assign m_axis_tdata = {5'd0, index, head_word};
    assign m_axis_tlast = (index == 3'd7);

endmodule

>>> rtl/sha256_datapath.sv
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output word_t      head_word
);

    word_t w_reg [16];
    word_t w_next [16];
    word_t h_reg [8];
    word_t h_next [8];
    word_t v_reg [8];
    word_t v_next [8];
    logic [6:0] round_reg, round_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    word_t s0, s1, wnew, t1, t2, e, a, wt, wrd;
    logic [1:0] lane;

    always_comb
    begin
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        wt   = w_reg[0];
        e    = v_reg[4];
        a    = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + RoundK[round_reg[5:0]] + wt;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        lane = 2'd3 - cmd.byte_addr[1:0];
        wrd  = w_reg[cmd.byte_addr[5:2]];
        wrd[lane*8 +: 8] = cmd.byte_value;

        w_next     = w_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (cmd.write_byte)
        begin
            w_next[cmd.byte_addr[5:2]] = wrd;
        end
        if (cmd.start_block)
        begin
            v_next     = h_reg;
            round_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = wnew;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            round_next = round_reg + 7'd1;
            if (round_reg == 7'(NumRounds - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        if (done_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end
        if (cmd.shift_digest)
        begin
            for (int i = 0; i < 7; i++)
            begin
                h_next[i] = h_reg[i+1];
            end
            h_next[7] = h_reg[0];
        end
        if (cmd.load_init)
        begin
            h_next = InitH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg     <= InitH;
            round_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            h_reg     <= h_next;
            round_reg <= round_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    assign status.busy = busy_reg | done_reg;
    assign status.done = done_reg;
    assign head_word   = h_reg[0];

endmodule

>>> rtl/sha256_control.sv
module sha256_control
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_op,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_index,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HASH  = 6'b000010,
        ST_PAD   = 6'b000100,
        ST_PHASH = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_WAIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] total_reg, total_next;
    logic final_reg, final_next;
    logic [2:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        total_next = total_reg;
        final_next = final_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.byte_addr = fill_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.write_byte = 1'b1;
                    if (!in_op)
                    begin
                        cmd.byte_value = in_byte;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            cmd.start_block = 1'b1;
                            state_next = ST_HASH;
                        end
                    end
                    else
                    begin
                        cmd.byte_value = 8'h80;
                        total_next = bits_reg + {55'd0, fill_reg, 3'd0};
                        fill_next  = fill_reg + 6'd1;
                        final_next = (fill_reg < 6'd56);
                        if (fill_reg == 6'd63)
                        begin
                            cmd.start_block = 1'b1;
                            state_next = ST_PHASH;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_HASH:
            begin
                if (status.done)
                begin
                    bits_next  = bits_reg + 64'd512;
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                cmd.write_byte = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (fill_reg >= 6'd56 && final_reg)
                begin
                    cmd.byte_value = total_reg[8*(63 - fill_reg) +: 8];
                end
                else
                begin
                    cmd.byte_value = 8'h00;
                end
                if (fill_reg == 6'd63)
                begin
                    cmd.start_block = 1'b1;
                    state_next = ST_PHASH;
                end
            end
            ST_PHASH:
            begin
                if (status.done)
                begin
                    if (final_reg)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        final_next = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_WAIT:
            begin
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.shift_digest = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.load_init = 1'b1;
                        bits_next  = '0;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The final_reg flag marks the padding block that carries the message length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            total_reg <= '0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            total_reg <= total_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_index = idx_reg;

endmodule

>>> rtl/sha256_checker.sv
module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("Input accepted while digest is being sent.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
        else $error("Digest words are not sent back to back in order.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("Block did not return to idle after the digest.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Stalled digest word changed.");

endmodule

bind sha256_stream_hasher_unit sha256_checker u_checker (.*);

>>> verif/sha256_stream_hasher_unit_tb.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_tb;
    import sha256_pkg::*;

    localparam logic OpAbsorb = 1'b0;
    localparam logic OpFinish = 1'b1;
    localparam int unsigned CycleLimit = 400000;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } byte_item_t;

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } digest_item_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic m_axis_tlast;

    sha256_stream_hasher_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    byte_item_t   pending_bytes[$];
    digest_item_t expected_words[$];

    word_t       model_hash[8];
    logic [7:0]  model_block[64];
    int unsigned model_fill;
    logic [63:0] model_bits;

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_request;
    bit          stimulus_done;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_model_block();
        word_t w[64];
        word_t v[8];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++)
            w[i] = {model_block[4*i], model_block[4*i+1], model_block[4*i+2],
                    model_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        v = model_hash;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            model_hash[i] = model_hash[i] + v[i];
    endtask

    task automatic restart_model();
        model_hash = InitH;
        model_fill = 0;
        model_bits = '0;
    endtask

    task automatic predict_hash(input byte_item_t item);
        int unsigned pos;
        logic [63:0] total;
        digest_item_t word_out;
        if (item.op == OpAbsorb)
        begin
            model_block[model_fill] = item.data_byte;
            model_fill++;
            if (model_fill == 64)
            begin
                compress_model_block();
                model_bits += 64'd512;
                model_fill = 0;
            end
        end
        else
        begin
            pos = model_fill;
            total = model_bits + 64'(pos * 8);
            model_block[pos] = 8'h80;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64) begin model_block[pos] = 8'h00; pos++; end
                compress_model_block();
                pos = 0;
            end
            while (pos < 56) begin model_block[pos] = 8'h00; pos++; end
            for (int i = 0; i < 8; i++)
                model_block[56+i] = total[63-8*i -: 8];
            compress_model_block();
            for (int i = 0; i < 8; i++)
            begin
                word_out.digest_word = model_hash[i];
                word_out.word_index = 3'(i);
                word_out.last_word = (i == 7);
                expected_words.push_back(word_out);
            end
            restart_model();
        end
    endtask

    task automatic queue_message(input int unsigned length);
        byte_item_t item;
        for (int unsigned i = 0; i < length; i++)
        begin
            item.op = OpAbsorb;
            item.data_byte = 8'($urandom_range(0, 255));
            pending_bytes.push_back(item);
        end
        item.op = OpFinish;
        item.data_byte = 8'($urandom_range(0, 255));
        pending_bytes.push_back(item);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        byte_item_t item;
        int unsigned random_count;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        hold_request = 1'b0;
        error_count = 0;
        restart_model();
        for (int i = 0; i < 64; i++) model_block[i] = 8'h00;

        item.op = OpFinish; item.data_byte = 8'hff;
        pending_bytes.push_back(item);
        item.op = OpAbsorb; item.data_byte = 8'h00;
        pending_bytes.push_back(item);
        item.data_byte = 8'hff;
        pending_bytes.push_back(item);
        item.data_byte = 8'h5a;
        pending_bytes.push_back(item);
        item.op = OpFinish; item.data_byte = 8'h00;
        pending_bytes.push_back(item);
        queue_message(0);
        queue_message(2);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        hold_request = 1'b1;
        queue_message(63);
        wait (pending_bytes.size() == 0 && expected_words.size() == 0);
        hold_request = 1'b0;

        queue_message(55);
        queue_message(56);
        queue_message(64);
        wait (pending_bytes.size() == 0 && expected_words.size() == 0);
        random_count = 0;
        while (random_count < 30)
        begin
            automatic int unsigned len = ($urandom_range(0, 9) == 0)
                                         ? $urandom_range(30, 70)
                                         : $urandom_range(0, 20);
            queue_message(len);
            random_count += len + 1;
        end
        stimulus_done = 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= OpAbsorb;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            automatic bit fired = s_axis_tvalid && s_axis_tready;
            automatic bit holding = s_axis_tvalid && !fired;
            if (fired)
            begin
                predict_hash(pending_bytes.pop_front());
            end
            if (holding)
            begin
            end
            else if (gap_left != 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_bytes.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_bytes[0].data_byte;
                s_axis_tuser <= pending_bytes[0].op;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 600;
        end
        else if (hold_request && hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ((cycle_count / 500) % 3 == 0)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= $urandom_range(1, 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            automatic digest_item_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected digest word %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata[31:0] !== want.digest_word)
                begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.digest_word, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[34:32] !== want.word_index)
                begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.word_index, m_axis_tdata[34:32]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last_word)
                begin
                    $display("%0t: last_word expected %b actual %b", $time,
                             want.last_word, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (pending_bytes.size() == 0 && !s_axis_tvalid && expected_words.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sha256_stream_hasher_unit.f
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_control.sv
rtl/sha256_stream_hasher_unit.sv
rtl/sha256_checker.sv
verif/sha256_stream_hasher_unit_tb.sv
